@@ hw/rtl/sst_pkg.sv @@
// Shared types and constants for the session socket tracker.
`default_nettype none
package sst_pkg;

  localparam int unsigned HANDLE_W = 64;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned ERR_W    = 16;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ENTRY_W  = HANDLE_W + PORT_W;

  // Event kinds
  localparam logic [1:0] MODE_CONNECT = 2'd0;
  localparam logic [1:0] MODE_RECV    = 2'd1;
  localparam logic [1:0] MODE_WAKE    = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_NEW      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOST_CLN = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOST_ABR = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SHUTDOWN = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd4;

  // Receive error codes that mean the connection is gone
  localparam logic [ERR_W-1:0] ERR_CONN_RESET   = 16'd10054;
  localparam logic [ERR_W-1:0] ERR_CONN_ABORTED = 16'd10053;
  localparam logic [ERR_W-1:0] ERR_NET_RESET    = 16'd10052;
  localparam logic [ERR_W-1:0] ERR_TIMED_OUT    = 16'd10060;
  localparam logic [ERR_W-1:0] ERR_SHUT_DOWN    = 16'd10058;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_EN   = 2'd3;

  localparam logic [PORT_W-1:0] BAND_LOW_RST  = 16'd51241;
  localparam logic [PORT_W-1:0] BAND_HIGH_RST = 16'd51250;

  typedef struct packed {
    logic [1:0]                mode;
    logic [HANDLE_W-1:0]       socket_handle;
    logic [PORT_W-1:0]         port_number;
    logic signed [COUNT_W-1:0] recv_count;
    logic [ERR_W-1:0]          error_code;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle_out;
    logic [PORT_W-1:0]   port_out;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PORT_W-1:0]   port;
  } entry_t;

  typedef struct packed {
    logic                watch_en;
    logic [PORT_W-1:0]   band_low;
    logic [PORT_W-1:0]   band_high;
    logic                wake_en;
  } cfg_t;

  typedef struct packed {
    logic nonzero;
    logic key_eq;
  } cmp_t;

endpackage
`default_nettype wire

@@ hw/rtl/sst_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sst_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/sst_cmp.sv @@
// Entry compare unit: effective handle of one table entry against the event key.
`default_nettype none
module sst_cmp (
  input  wire logic                           entry_valid,
  input  wire logic [sst_pkg::HANDLE_W-1:0]   entry_handle,
  input  wire logic [sst_pkg::HANDLE_W-1:0]   key_handle,
  output sst_pkg::cmp_t                       res
);
  import sst_pkg::*;

  logic [HANDLE_W-1:0] eff_handle;

  // An entry that was never filled or was cleared reads as handle zero.
  assign eff_handle  = entry_valid ? entry_handle : '0;
  assign res.nonzero = (eff_handle != '0);
  assign res.key_eq  = (eff_handle == key_handle);

endmodule
`default_nettype wire

@@ hw/rtl/sst_seq.sv @@
// Scan sequencer: walks the table one entry a cycle unless stalled, and forms the results.
`default_nettype none
module sst_seq #(
  parameter int unsigned ENTRIES = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sst_pkg::cfg_t              cfg,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire sst_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output sst_pkg::out_item_t              out_data,
  input  wire sst_pkg::entry_t            rd_entry,
  input  wire sst_pkg::cmp_t              cmp,
  output logic                            cur_valid,
  output logic [sst_pkg::HANDLE_W-1:0]    key_handle,
  output logic [$clog2(ENTRIES)-1:0]      rd_addr,
  output logic                            wr_en,
  output logic [$clog2(ENTRIES)-1:0]      wr_addr,
  output sst_pkg::entry_t                 wr_entry
);
  import sst_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT,
    S_WAKE_END
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    ring_r, ring_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  in_item_t            key_r, key_nxt;
  logic                in_band_r, in_band_nxt;
  logic [KIND_W-1:0]   lost_kind_r, lost_kind_nxt;
  logic                pend_v_r, pend_v_nxt;
  entry_t              pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                out_free;
  logic                band_hit;
  logic                err_drop;
  logic                recv_dead;
  logic                at_last;

  assign out_free  = !out_valid_r || !out_stall;
  assign at_last   = (idx_r == LAST_IDX);
  assign band_hit  = (in_data.port_number >= cfg.band_low) &&
                     (in_data.port_number <= cfg.band_high);
  assign err_drop  = (in_data.error_code == ERR_CONN_RESET) ||
                     (in_data.error_code == ERR_CONN_ABORTED) ||
                     (in_data.error_code == ERR_NET_RESET) ||
                     (in_data.error_code == ERR_TIMED_OUT) ||
                     (in_data.error_code == ERR_SHUT_DOWN);
  assign recv_dead = (in_data.recv_count == '0) ||
                     (in_data.recv_count < 0 && err_drop);

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cur_valid  = valid_r[idx_r];
  assign key_handle = key_r.socket_handle;
  assign rd_addr    = idx_nxt;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ring_nxt      = ring_r;
    valid_nxt     = valid_r;
    key_nxt       = key_r;
    in_band_nxt   = in_band_r;
    lost_kind_nxt = lost_kind_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_entry      = '{handle: key_r.socket_handle, port: key_r.port_number};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_valid) begin
          key_nxt       = in_data;
          in_band_nxt   = band_hit;
          lost_kind_nxt = (in_data.recv_count == '0) ? KIND_LOST_CLN : KIND_LOST_ABR;
          pend_v_nxt    = 1'b0;
          if (cfg.watch_en) begin
            unique case (in_data.mode)
              MODE_CONNECT: state_nxt = S_SCAN;
              MODE_RECV:    if (recv_dead) state_nxt = S_SCAN;
              MODE_WAKE:    if (cfg.wake_en) state_nxt = S_SCAN;
              default:      state_nxt = S_IDLE;
            endcase
          end
        end
      end

      S_SCAN: begin
        unique case (key_r.mode)
          MODE_CONNECT: begin
            if (cmp.key_eq && in_band_r) begin
              // Refresh the port of the first holder and stop.
              wr_en     = 1'b1;
              wr_addr   = idx_r;
              state_nxt = S_IDLE;
              idx_nxt   = '0;
            end else begin
              if (cmp.key_eq) begin
                valid_nxt[idx_r] = 1'b0;
              end
              if (at_last) begin
                state_nxt = in_band_r ? S_INSERT : S_IDLE;
                idx_nxt   = '0;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
          end

          MODE_RECV: begin
            if (cmp.key_eq && cmp.nonzero) begin
              if (out_free) begin
                valid_nxt[idx_r] = 1'b0;
                out_valid_nxt    = 1'b1;
                out_data_nxt     = '{kind: lost_kind_r, handle_out: key_r.socket_handle,
                                     port_out: rd_entry.port, last: 1'b1};
                state_nxt        = S_IDLE;
                idx_nxt          = '0;
              end
            end else if (at_last) begin
              state_nxt = S_IDLE;
              idx_nxt   = '0;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end

          default: begin
            // Wake: hold one found entry back so the final one can be flagged last.
            if (cmp.nonzero && pend_v_r && !out_free) begin
              idx_nxt = idx_r;
            end else begin
              if (cmp.nonzero) begin
                if (pend_v_r) begin
                  out_valid_nxt = 1'b1;
                  out_data_nxt  = '{kind: KIND_SHUTDOWN, handle_out: pend_r.handle,
                                    port_out: pend_r.port, last: 1'b0};
                end
                pend_v_nxt = 1'b1;
                pend_nxt   = rd_entry;
              end
              if (at_last) begin
                state_nxt = S_WAKE_END;
                idx_nxt   = '0;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
          end
        endcase
      end

      S_INSERT: begin
        idx_nxt = '0;
        if (out_free) begin
          wr_en             = 1'b1;
          wr_addr           = ring_r;
          valid_nxt[ring_r] = 1'b1;
          ring_nxt          = (ring_r == LAST_IDX) ? '0 : ring_r + 1'b1;
          out_valid_nxt     = 1'b1;
          out_data_nxt      = '{kind: KIND_NEW, handle_out: key_r.socket_handle,
                                port_out: key_r.port_number, last: 1'b1};
          state_nxt         = S_IDLE;
        end
      end

      S_WAKE_END: begin
        idx_nxt = '0;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pend_v_r) begin
            out_data_nxt = '{kind: KIND_SHUTDOWN, handle_out: pend_r.handle,
                             port_out: pend_r.port, last: 1'b1};
          end else begin
            out_data_nxt = '{kind: KIND_NONE, handle_out: '0, port_out: '0, last: 1'b1};
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      ring_r      <= '0;
      valid_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      ring_r      <= ring_nxt;
      valid_r     <= valid_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r       <= key_nxt;
    in_band_r   <= in_band_nxt;
    lost_kind_r <= lost_kind_nxt;
    pend_r      <= pend_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule
`default_nettype wire

@@ hw/rtl/session_socket_tracker_unit.sv @@
// Session socket tracker: an event is accepted, then the table is walked entry by entry
// through the single read port of the table RAM, then an insert or the final wake result
// is given; a matching connect or receive ends early, an ignored event is accepted with no
// scan. A new event is taken only after the previous ends. Output stalls stretch the scan.
// Reset empties the table at once through per-entry valid flags, zeroes the ring pointer
// and loads the register defaults.
`default_nettype none
module session_socket_tracker_unit #(
  parameter int unsigned TRACKED_ENTRIES = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire sst_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output sst_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [sst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sst_pkg::CFG_W-1:0]       cfg_wdata
);
  import sst_pkg::*;

  localparam int unsigned IDX_W = $clog2(TRACKED_ENTRIES);

  cfg_t                cfg_r, cfg_nxt;
  entry_t              rd_entry;
  entry_t              wr_entry;
  cmp_t                cmp;
  logic                cur_valid;
  logic [HANDLE_W-1:0] key_handle;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic                wr_en;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WATCH_EN:  cfg_nxt.watch_en  = cfg_wdata[0];
        CFG_BAND_LOW:  cfg_nxt.band_low  = cfg_wdata;
        CFG_BAND_HIGH: cfg_nxt.band_high = cfg_wdata;
        CFG_WAKE_EN:   cfg_nxt.wake_en   = cfg_wdata[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{watch_en: 1'b1, band_low: BAND_LOW_RST, band_high: BAND_HIGH_RST,
                 wake_en: 1'b1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TRACKED_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  sst_cmp u_cmp (
    .entry_valid  (cur_valid),
    .entry_handle (rd_entry.handle),
    .key_handle   (key_handle),
    .res          (cmp)
  );

  sst_seq #(
    .ENTRIES (TRACKED_ENTRIES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .rd_entry   (rd_entry),
    .cmp        (cmp),
    .cur_valid  (cur_valid),
    .key_handle (key_handle),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_entry   (wr_entry)
  );

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for the session socket tracker: directed rows, then random traffic.
`timescale 1ns / 100ps
module tb_top;
  import sst_pkg::*;

  localparam int ENTRIES     = 32;
  localparam int POOL        = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = ENTRIES + 4;
  localparam int LIMIT       = 400000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    in_item_t  ev;
    bit        typed;
    int        n;
    out_item_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Shadow of the block: registers, handle table, ring pointer
  bit          sh_watch = 1'b1;
  bit [15:0]   sh_lo = BAND_LOW_RST;
  bit [15:0]   sh_hi = BAND_HIGH_RST;
  bit          sh_wake = 1'b1;
  bit [63:0]   tbl_handle [ENTRIES];
  bit [15:0]   tbl_port [ENTRIES];
  int unsigned ring_ptr = 0;

  out_item_t   pending_reports [$];
  out_item_t   oldest_report;
  bit [63:0]   handle_pool [POOL];
  dir_row_t    dir_rows [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  session_socket_tracker_unit #(.TRACKED_ENTRIES(ENTRIES)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("session_socket_tracker_unit test failed");
      $finish;
    end
  end

  task automatic flag_mismatch(string what);
    mismatch_count++;
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  function automatic out_item_t mk_res(logic [KIND_W-1:0] k, logic [63:0] h,
                                       logic [15:0] p, logic l);
    out_item_t r;
    r.kind = k;
    r.handle_out = h;
    r.port_out = p;
    r.last = l;
    return r;
  endfunction

  function automatic in_item_t mk_ev(logic [1:0] m, logic [63:0] h, logic [15:0] p,
                                     logic [31:0] c, logic [15:0] e);
    in_item_t ev;
    ev.mode = m;
    ev.socket_handle = h;
    ev.port_number = p;
    ev.recv_count = c;
    ev.error_code = e;
    return ev;
  endfunction

  // Apply one event to the shadow table and list the reports it should give
  function automatic void predict_tracking(input in_item_t ev, output out_item_t res[$]);
    int  cnt;
    bit  in_band;
    bit  dead;
    res = {};
    cnt = ev.recv_count;
    if (!sh_watch) return;
    case (ev.mode)
      MODE_CONNECT: begin
        in_band = ev.port_number >= sh_lo && ev.port_number <= sh_hi;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_handle[i] == ev.socket_handle) begin
            if (in_band) begin
              tbl_port[i] = ev.port_number;
              return;
            end
            tbl_handle[i] = '0;
          end
        end
        if (in_band) begin
          tbl_handle[ring_ptr] = ev.socket_handle;
          tbl_port[ring_ptr] = ev.port_number;
          ring_ptr = (ring_ptr + 1) % ENTRIES;
          res.push_back(mk_res(KIND_NEW, ev.socket_handle, ev.port_number, 1'b1));
        end
      end
      MODE_RECV: begin
        dead = cnt == 0 || ev.error_code inside {ERR_CONN_RESET, ERR_CONN_ABORTED,
                                                  ERR_NET_RESET, ERR_TIMED_OUT,
                                                  ERR_SHUT_DOWN};
        if (cnt <= 0 && dead) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_handle[i] != 0 && tbl_handle[i] == ev.socket_handle) begin
              res.push_back(mk_res(cnt == 0 ? KIND_LOST_CLN : KIND_LOST_ABR,
                                   ev.socket_handle, tbl_port[i], 1'b1));
              tbl_handle[i] = '0;
              return;
            end
          end
        end
      end
      MODE_WAKE: begin
        if (sh_wake) begin
          for (int i = 0; i < ENTRIES; i++)
            if (tbl_handle[i] != 0)
              res.push_back(mk_res(KIND_SHUTDOWN, tbl_handle[i], tbl_port[i], 1'b0));
          if (res.size() == 0) res.push_back(mk_res(KIND_NONE, '0, '0, 1'b1));
          else res[res.size()-1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(in_item_t ev, bit typed = 1'b0, int n = 0,
                                  out_item_t res = '0);
    dir_row_t row;
    row.ev = ev;
    row.typed = typed;
    row.n = n;
    row.res = res;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [15:0] pick_port(bit [15:0] lo, bit [15:0] hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65 && lo <= hi) return 16'($urandom_range(hi, lo));
    if (r < 70) return lo - 16'd1;
    if (r < 75) return hi + 16'd1;
    if (r < 78) return 16'h0000;
    if (r < 82) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 32'd0;
    if (r < 65) return -32'($urandom_range(1, 100));
    if (r < 70) return 32'h8000_0000;
    if (r < 75) return 32'h7FFF_FFFF;
    if (r < 87) return 32'($urandom_range(1, 5000));
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_err();
    if ($urandom_range(0, 99) >= 65) return 16'($urandom);
    case ($urandom_range(0, 4))
      0: return ERR_CONN_RESET;
      1: return ERR_CONN_ABORTED;
      2: return ERR_NET_RESET;
      3: return ERR_TIMED_OUT;
      default: return ERR_SHUT_DOWN;
    endcase
  endfunction

  // Offer one event, hold it until the transfer, then queue its reports
  task automatic send_event(in_item_t ev, bit typed, out_item_t want[$]);
    out_item_t got [$];
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (in_stall);
    predict_tracking(ev, got);
    if (typed) got = want;
    foreach (got[i]) pending_reports.push_back(got[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reconfigure(bit watch, bit [15:0] lo, bit [15:0] hi, bit wake);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_WATCH_EN;
    cfg_wdata <= CFG_W'(watch);
    @(posedge clk);
    cfg_index <= CFG_BAND_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_BAND_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= CFG_WAKE_EN;
    cfg_wdata <= CFG_W'(wake);
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_watch = watch;
    sh_lo = lo;
    sh_hi = hi;
    sh_wake = wake;
    @(posedge clk);
  endtask

  task automatic run_random(int n, int conn_w, int recv_w, int fresh_pct);
    out_item_t none [$];
    logic [1:0]  m;
    logic [63:0] h;
    int          r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < conn_w) m = MODE_CONNECT;
      else if (r < conn_w + recv_w) m = MODE_RECV;
      else if (r < 98) m = MODE_WAKE;
      else m = MODE_UNUSED;
      if ($urandom_range(0, 99) < fresh_pct) h = {$urandom, $urandom};
      else h = handle_pool[$urandom_range(0, POOL-1)];
      send_event(mk_ev(m, h, pick_port(sh_lo, sh_hi), pick_count(), pick_err()), 1'b0, none);
    end
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_stall <= !calm && $urandom_range(0, 99) < 32;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch($sformatf("unexpected report kind %0d handle %h port %0d",
                                out_data.kind, out_data.handle_out, out_data.port_out));
      end else begin
        oldest_report = pending_reports.pop_front();
        if (out_data.kind !== oldest_report.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", out_data.kind, oldest_report.kind));
        if (out_data.handle_out !== oldest_report.handle_out)
          flag_mismatch($sformatf("handle %h, want %h", out_data.handle_out,
                                  oldest_report.handle_out));
        if (out_data.port_out !== oldest_report.port_out)
          flag_mismatch($sformatf("port %0d, want %0d", out_data.port_out,
                                  oldest_report.port_out));
        if (out_data.last !== oldest_report.last)
          flag_mismatch($sformatf("last %0b, want %0b", out_data.last, oldest_report.last));
      end
    end
  end

  initial begin
    out_item_t   want [$];
    out_item_t   none [$];
    int          empties;
    logic [63:0] hmax;
    logic [63:0] h1;
    logic [63:0] h3;
    hmax = '1;
    h1 = 64'h0123_4567_89AB_CDEF;
    h3 = 64'h8000_0000_0000_0001;
    foreach (tbl_handle[i]) begin
      tbl_handle[i] = '0;
      tbl_port[i] = '0;
    end
    handle_pool[0] = '0;
    handle_pool[1] = '1;
    handle_pool[2] = 64'h8000_0000_0000_0000;
    for (int i = 3; i < POOL; i++) handle_pool[i] = {$urandom, $urandom};

    add_row(mk_ev(MODE_WAKE, '0, '0, '0, '0), 1, 1, mk_res(KIND_NONE, '0, '0, 1'b1));
    add_row(mk_ev(MODE_RECV, hmax, '0, 32'd0, '0), 1, 0);
    add_row(mk_ev(MODE_CONNECT, hmax, 16'd51241, '0, '0), 1, 1,
            mk_res(KIND_NEW, hmax, 16'd51241, 1'b1));
    add_row(mk_ev(MODE_CONNECT, h1, 16'd51250, '0, '0), 1, 1,
            mk_res(KIND_NEW, h1, 16'd51250, 1'b1));
    add_row(mk_ev(MODE_CONNECT, 64'd2, 16'd51240, '0, '0), 1, 0);
    add_row(mk_ev(MODE_CONNECT, 64'd2, 16'd51251, '0, '0), 1, 0);
    add_row(mk_ev(MODE_CONNECT, h1, 16'd51245, '0, '0));
    // handle zero lands on the first empty entry and leaves it empty
    add_row(mk_ev(MODE_CONNECT, '0, 16'd51242, '0, '0), 1, 0);
    add_row(mk_ev(MODE_UNUSED, hmax, 16'd51241, 32'd0, ERR_CONN_RESET), 1, 0);
    add_row(mk_ev(MODE_RECV, h1, '0, 32'h7FFF_FFFF, ERR_CONN_RESET), 1, 0);
    add_row(mk_ev(MODE_RECV, h1, '0, 32'hFFFF_FFFF, 16'hFFFF), 1, 0);
    add_row(mk_ev(MODE_RECV, '0, '0, 32'd0, '0), 1, 0);
    add_row(mk_ev(MODE_WAKE, '1, '1, '1, '1));
    add_row(mk_ev(MODE_RECV, h1, '0, 32'hFFFF_FFFF, ERR_CONN_RESET));
    add_row(mk_ev(MODE_RECV, hmax, '0, 32'd0, '0), 1, 1,
            mk_res(KIND_LOST_CLN, hmax, 16'd51241, 1'b1));
    add_row(mk_ev(MODE_CONNECT, h3, 16'd51243, '0, '0));
    add_row(mk_ev(MODE_RECV, h3, '0, 32'h8000_0000, ERR_CONN_ABORTED), 1, 1,
            mk_res(KIND_LOST_ABR, h3, 16'd51243, 1'b1));
    add_row(mk_ev(MODE_CONNECT, 64'd4, 16'd51244, '0, '0));
    add_row(mk_ev(MODE_RECV, 64'd4, '0, -32'sd5, ERR_NET_RESET), 1, 1,
            mk_res(KIND_LOST_ABR, 64'd4, 16'd51244, 1'b1));
    add_row(mk_ev(MODE_CONNECT, 64'd5, 16'd51246, '0, '0));
    add_row(mk_ev(MODE_RECV, 64'd5, '0, 32'hFFFF_FFFF, ERR_TIMED_OUT), 1, 1,
            mk_res(KIND_LOST_ABR, 64'd5, 16'd51246, 1'b1));
    add_row(mk_ev(MODE_CONNECT, 64'd6, 16'd51247, '0, '0));
    add_row(mk_ev(MODE_RECV, 64'd6, '0, 32'hFFFF_FFFF, ERR_SHUT_DOWN), 1, 1,
            mk_res(KIND_LOST_ABR, 64'd6, 16'd51247, 1'b1));
    add_row(mk_ev(MODE_CONNECT, 64'd6, 16'd51248, '0, '0));
    // out of band: drop the entry again
    add_row(mk_ev(MODE_CONNECT, 64'd6, 16'd0, '0, '0), 1, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      want = {};
      if (dir_rows[i].n == 1) want.push_back(dir_rows[i].res);
      send_event(dir_rows[i].ev, dir_rows[i].typed, want);
    end

    // Full band: fill the ring under a long receiver hold-off
    reconfigure(1'b1, 16'h0000, 16'hFFFF, 1'b1);
    hold_req = 1'b1;
    run_random(45, 92, 4, 70);
    for (int guard = 0; guard < 2 * ENTRIES; guard++) begin
      empties = 0;
      foreach (tbl_handle[i]) if (tbl_handle[i] == 0) empties++;
      if (empties == 0) break;
      send_event(mk_ev(MODE_CONNECT, {$urandom, $urandom}, 16'($urandom), $urandom,
                       16'($urandom)), 1'b0, none);
    end
    // full table: handle zero is inserted like any other
    send_event(mk_ev(MODE_CONNECT, '0, 16'($urandom), $urandom, 16'($urandom)), 1'b0, none);
    drain();
    run_random(60, 50, 40, 25);

    reconfigure(1'b1, 16'd1000, 16'd1031, 1'b1);
    calm = 1'b1;
    run_random(50, 50, 40, 30);
    calm = 1'b0;

    reconfigure(1'b1, 16'hFFFF, 16'h0000, 1'b1);
    run_random(20, 55, 35, 20);
    reconfigure(1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
    run_random(20, 40, 30, 20);
    reconfigure(1'b0, 16'h0000, 16'hFFFF, 1'b1);
    run_random(15, 40, 30, 30);
    reconfigure(1'b1, BAND_LOW_RST, BAND_HIGH_RST, 1'b1);
    run_random(30, 50, 40, 20);
    send_event(mk_ev(MODE_WAKE, '0, '0, '0, '0), 1'b0, none);

    drain();
    if (mismatch_count == 0) begin
      $display("session_socket_tracker_unit test passed");
    end else begin
      $display("session_socket_tracker_unit test failed");
    end
    $finish;
  end

endmodule
